### rtl/core/mcllm_pkg.sv
// ----------------------------------------------------------------------------
// mcllm_pkg
// Types and constants for the multi-channel link-loss monitor.
// ----------------------------------------------------------------------------
package mcllm_pkg;

	// item kinds carried on the input tuser
	typedef enum logic [2:0] {
		MODE_TICK    = 3'd0,
		MODE_RECEIVE = 3'd1,
		MODE_CHECK   = 3'd2,
		MODE_QUERY   = 3'd3,
		MODE_ARM     = 3'd4
	} mode_t;

	// event codes carried on the output tuser
	typedef enum logic [1:0] {
		EV_ONLINE    = 2'd0,
		EV_LOST      = 2'd1,
		EV_RECOVERED = 2'd2
	} event_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_TMO_LOW   = 2'd0,
		CFG_TMO_HIGH  = 2'd1,
		CFG_LOST_MASK = 2'd2
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_QUERY
	} state_t;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned TMO_W  = 16;
	localparam int unsigned CH_W   = 3;

	// fifty ticks for each of four channels
	localparam logic [63:0] TMO_RESET = 64'h0032_0032_0032_0032;

endpackage

### rtl/core/multi_channel_link_loss_monitor.sv
// Sequencing: tick, receive, arm and unused kinds are handled when accepted; a query
// passes through ST_QUERY and its result is registered; a check scans the channels
// in order, one channel per cycle unless the output stalls, through the shared
// 32-bit subtract and compare unit. No new item is taken while a check or query runs.
// Reset: counter, timestamps and lost flags cleared, timeouts set to 50 ticks,
// arm mask cleared, no result pending.
// ----------------------------------------------------------------------------
// multi_channel_link_loss_monitor
// Per-channel link-loss watchdog with a tick counter, receive stamps, a
// sequential check scan, channel queries and a loadable lost mask.
// ----------------------------------------------------------------------------
module multi_channel_link_loss_monitor
	import mcllm_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] channel, [7:3] zero
	input  logic [2:0]  s_tuser,   // [2:0] mode
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] channel_res, [3] lost, [7:4] zero
	output logic [1:0]  m_tuser,   // [1:0] event_res
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W:0]   NCH     = (CH_W + 1)'(NUM_CHANNELS);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	// state
	state_t                  state_q, state_d;
	logic [TIME_W-1:0]       time_q;
	logic [TIME_W-1:0]       lrt_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] lost_q;
	logic [63:0]             tmo_low_q, tmo_high_q;
	logic [7:0]              mask_q;
	logic [CH_W-1:0]         scan_q;

	// output register
	logic            out_valid_q;
	logic [CH_W-1:0] out_ch_q;
	logic            out_lost_q;
	event_t          out_ev_q;
	logic            out_last_q;

	// control
	logic            in_acc;
	mode_t           in_mode;
	logic [CH_W-1:0] in_ch;
	logic            adv;
	logic            scan_step, query_step, scan_end;

	assign in_mode = mode_t'(s_tuser);
	assign in_ch   = s_tdata[CH_W-1:0];
	assign in_acc  = s_tvalid && s_tready;
	assign adv     = !out_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_mode == MODE_CHECK) state_d = ST_SCAN;
				else if (in_acc && in_mode == MODE_QUERY) state_d = ST_QUERY;
			end
			ST_SCAN: begin
				if (adv && scan_q == LAST_CH) state_d = ST_IDLE;
			end
			ST_QUERY: begin
				if (adv) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready   = 1'b0;
		scan_step  = 1'b0;
		query_step = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready   = 1'b1;
			ST_SCAN:  scan_step  = adv;
			ST_QUERY: query_step = adv;
			default:  s_tready   = 1'b0;
		endcase
	end

	assign scan_end = scan_q == LAST_CH;

	// shared elapsed-time unit: one subtract and compare per cycle
	logic [TIME_W-1:0] elapsed;
	logic [63:0]       tmo_word;
	logic [TMO_W-1:0]  tmo;
	logic              timed_out;
	logic              cur_lost;
	logic              q_in_range;

	assign elapsed    = time_q - lrt_q[scan_q[IDX_W-1:0]];
	assign tmo_word   = scan_q[2] ? tmo_high_q : tmo_low_q;
	assign tmo        = tmo_word[{scan_q[1:0], 4'b0000} +: TMO_W];
	assign timed_out  = elapsed > {{(TIME_W - TMO_W){1'b0}}, tmo};
	assign cur_lost   = lost_q[scan_q[IDX_W-1:0]];
	assign q_in_range = {1'b0, scan_q} < NCH;

	// sequencer state and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc && in_mode == MODE_CHECK) scan_q <= '0;
			else if (in_acc && in_mode == MODE_QUERY) scan_q <= in_ch;
			else if (scan_step && !scan_end) scan_q <= scan_q + 1'b1;
		end
	end

	// tick counter and receive stamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) lrt_q[i] <= '0;
		end else if (in_acc) begin
			if (in_mode == MODE_TICK) time_q <= time_q + 1'b1;
			if (in_mode == MODE_RECEIVE && ({1'b0, in_ch} < NCH))
				lrt_q[in_ch[IDX_W-1:0]] <= time_q;
		end
	end

	// lost flags: updated by the scan, loaded by an arm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_q <= '0;
		end else if (in_acc && in_mode == MODE_ARM) begin
			lost_q <= mask_q[NUM_CHANNELS-1:0];
		end else if (scan_step) begin
			if (timed_out) lost_q[scan_q[IDX_W-1:0]] <= 1'b1;
			else lost_q[scan_q[IDX_W-1:0]] <= 1'b0;
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_low_q  <= TMO_RESET;
			tmo_high_q <= TMO_RESET;
			mask_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TMO_LOW:   tmo_low_q  <= cfg_data;
				CFG_TMO_HIGH:  tmo_high_q <= cfg_data;
				CFG_LOST_MASK: mask_q     <= cfg_data[7:0];
				default:       mask_q     <= mask_q;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_step || query_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (scan_step) begin
			out_ch_q   <= scan_q;
			out_lost_q <= timed_out;
			out_last_q <= scan_end;
			if (timed_out) out_ev_q <= EV_LOST;
			else if (cur_lost) out_ev_q <= EV_RECOVERED;
			else out_ev_q <= EV_ONLINE;
		end else if (query_step) begin
			out_ch_q   <= scan_q;
			out_lost_q <= q_in_range ? cur_lost : 1'b0;
			out_last_q <= 1'b1;
			out_ev_q   <= EV_ONLINE;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_lost_q, out_ch_q};
	assign m_tuser  = out_ev_q;
	assign m_tlast  = out_last_q;

	// checks
	a_scan_emits: assert property (@(posedge clk) disable iff (!arst_n)
		scan_step |=> m_tvalid)
		else $error("scan step did not load a result");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_q <= LAST_CH)
		else $error("scan counter past last channel");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_step && scan_end) |=> (state_q == ST_IDLE && m_tlast))
		else $error("scan did not finish on last channel");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!scan_step && !(in_acc && in_mode == MODE_ARM)) |=> $stable(lost_q))
		else $error("lost flags changed outside scan or arm");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready)
		else $error("input taken while busy");

endmodule
